/* hw/rtl/pipw_pkg.sv */
// ----------------------------------------------------------------------------
// pipw_pkg: shared constants and types for the winding-number polygon test
// Holds the coordinate width, derived widths, verdict codes and the channel
// payload types used by the interfaces and the top level.
// ----------------------------------------------------------------------------
package pipw_pkg;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned PROD_BITS  = 2 * COORD_BITS + 2;
  localparam int unsigned CNT_BITS   = $clog2(PROD_BITS + 1);

  localparam logic [1:0] VERDICT_OUT    = 2'd0;
  localparam logic [1:0] VERDICT_IN     = 2'd1;
  localparam logic [1:0] VERDICT_BORDER = 2'd2;

  localparam logic CFG_TEST_LAT = 1'b0;
  localparam logic CFG_TEST_LON = 1'b1;

  typedef struct packed {
    logic signed [31:0] delta_lat;
    logic signed [31:0] delta_lon;
    logic               last_vertex;
  } in_req_t;

  typedef struct packed {
    logic [1:0] verdict;
  } out_req_t;

endpackage

/* hw/rtl/pipw_in_if.sv */
// ----------------------------------------------------------------------------
// pipw_in_if: vertex request channel
// Valid/ready channel carrying one polygon vertex delta per request.
// ----------------------------------------------------------------------------
interface pipw_in_if;
  logic              valid;
  logic              ready;
  pipw_pkg::in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/pipw_out_if.sv */
// ----------------------------------------------------------------------------
// pipw_out_if: verdict request channel
// Valid/ready channel carrying one verdict per closed polygon.
// ----------------------------------------------------------------------------
interface pipw_out_if;
  logic               valid;
  logic               ready;
  pipw_pkg::out_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/point_in_polygon_winding_top.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_winding_top: quadrant winding-number point-in-polygon test
// Accumulates vertex deltas into points, tracks quadrant changes around the
// configured test point and reports outside, inside or border per polygon.
//
//   channel  dir  handshake     payload
//   in_      in   valid/ready   delta_lat, delta_lon, last_vertex
//   out_     out  valid/ready   verdict
//   cfg_     in   write enable  index 0 test_lat, index 1 test_lon
//
// A plain vertex is accepted and then evaluated. A diagonal crossing that
// is not axis-aligned adds a bit-serial multiply and a restoring divide. A
// last item also evaluates the closing point, which may take a crossing of
// its own. Reset is synchronous and clears the sequencer, polygon
// accumulators, output valid and configuration. A verdict waits in the
// output register; items are taken meanwhile until the next verdict is due.
// ----------------------------------------------------------------------------
module point_in_polygon_winding_top (
  input  logic        clk,
  input  logic        rst_n,
  pipw_in_if.sink     in_ch,
  pipw_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned CB = pipw_pkg::COORD_BITS;
  localparam int unsigned PB = pipw_pkg::PROD_BITS;
  localparam int unsigned NB = pipw_pkg::CNT_BITS;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_CLOSE = 3'd5;
  localparam logic [2:0] ST_VERD  = 3'd6;

  logic [2:0] state_r, state_nxt;

  logic signed [CB-1:0] test_lat_r, test_lon_r;
  logic signed [CB-1:0] cur_lat_r, cur_lon_r, start_lat_r, start_lon_r;
  logic signed [CB-1:0] prior_lat_r, prior_lon_r;
  logic signed [CB-1:0] pt_lat_r, pt_lon_r;
  logic [1:0]  prior_q_r, q_r;
  logic [31:0] wind_r;
  logic        have_start_r, decided_r, last_r, closing_r;
  logic [1:0]  early_r;
  logic        out_valid_r;
  logic [1:0]  out_verdict_r;

  // Serial multiply/divide datapath.
  logic [PB-1:0] mcand_r, acc_r, rem_r, quo_r;
  logic [CB:0]   mplier_r, div_r;
  logic [NB-1:0] cnt_r;
  logic          neg_r;

  // Point evaluation combinational terms (narrow compares and adds).
  logic signed [CB:0] lat_e, lon_e, tlat_e, tlon_e, plat_e, plon_e;
  logic [1:0] q_c;
  logic       hit, straight, diag, step_up, step_dn, between_ok;
  logic signed [CB:0] rise, dlon, dlat;

  assign lat_e  = {pt_lat_r[CB-1], pt_lat_r};
  assign lon_e  = {pt_lon_r[CB-1], pt_lon_r};
  assign tlat_e = {test_lat_r[CB-1], test_lat_r};
  assign tlon_e = {test_lon_r[CB-1], test_lon_r};
  assign plat_e = {prior_lat_r[CB-1], prior_lat_r};
  assign plon_e = {prior_lon_r[CB-1], prior_lon_r};

  always_comb begin
    hit = (pt_lat_r == test_lat_r) && (pt_lon_r == test_lon_r);
    if (pt_lat_r >= test_lat_r) q_c = (pt_lon_r >= test_lon_r) ? 2'd0 : 2'd1;
    else                        q_c = (pt_lon_r >= test_lon_r) ? 2'd3 : 2'd2;
    step_up  = (q_c == prior_q_r + 2'd1);
    step_dn  = (q_c + 2'd1 == prior_q_r);
    diag     = (q_c != prior_q_r) && !step_up && !step_dn;
    straight = (pt_lon_r == prior_lon_r) || (pt_lat_r == prior_lat_r);
    between_ok =
      ((pt_lat_r <= test_lat_r && test_lat_r <= prior_lat_r) ||
       (prior_lat_r <= test_lat_r && test_lat_r <= pt_lat_r)) &&
      ((pt_lon_r <= test_lon_r && test_lon_r <= prior_lon_r) ||
       (prior_lon_r <= test_lon_r && test_lon_r <= pt_lon_r));
    rise = tlat_e - lat_e;
    dlon = lon_e - plon_e;
    dlat = lat_e - plat_e;
  end

  function automatic logic [CB:0] magf(input logic signed [CB:0] v);
    magf = v[CB] ? -v : v;
  endfunction

  // Restoring divide step.
  logic [PB:0] rem_sh;
  logic [PB:0] rem_sub;
  assign rem_sh  = {rem_r, quo_r[PB-1]};
  assign rem_sub = rem_sh - {{(PB-CB){1'b0}}, div_r};

  // Crossing result: k = lon +/- q, truncated toward zero, in wide arithmetic.
  localparam int unsigned KB = PB + 2;
  logic signed [KB-1:0] k_w, x_w, tl_w, lon_w;
  logic frac;
  always_comb begin
    lon_w = KB'(lon_e);
    tl_w  = KB'(tlon_e);
    frac  = (rem_r != '0);
    if (!neg_r)   k_w = lon_w + $signed({2'b00, quo_r});
    else if (frac) k_w = lon_w - $signed({2'b00, quo_r}) - KB'(1);
    else          k_w = lon_w - $signed({2'b00, quo_r});
    x_w = (k_w < 0 && frac) ? k_w + KB'(1) : k_w;
  end

  logic border_x, x_less;
  assign border_x = (x_w >= tl_w - KB'(1)) && (x_w <= tl_w + KB'(1));
  assign x_less   = (x_w < tl_w);

  logic in_acc, cfg_ok;
  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data.verdict = out_verdict_r;
  assign cfg_ok = cfg_we;

  logic [CB-1:0] dl, dn;
  logic          nz;
  assign dl = in_ch.data.delta_lat[CB-1:0];
  assign dn = in_ch.data.delta_lon[CB-1:0];
  assign nz = (dl != '0) || (dn != '0);

  // Next-state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!decided_r && nz) state_nxt = ST_EVAL;
          else if (in_ch.data.last_vertex) state_nxt = ST_CLOSE;
        end
      end
      ST_EVAL: begin
        if (decided_r || hit || !have_start_r) state_nxt = closing_r ? ST_VERD :
                                                 (last_r ? ST_CLOSE : ST_IDLE);
        else if (straight && (diag || between_ok)) state_nxt = closing_r ? ST_VERD :
                                                 (last_r ? ST_CLOSE : ST_IDLE);
        else if (!straight && diag) state_nxt = ST_MUL;
        else state_nxt = closing_r ? ST_VERD : (last_r ? ST_CLOSE : ST_IDLE);
      end
      ST_MUL:  if (cnt_r == NB'(PB - 1)) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == NB'(PB - 1)) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = closing_r ? ST_VERD : (last_r ? ST_CLOSE : ST_IDLE);
      ST_CLOSE: state_nxt = (!decided_r && have_start_r) ? ST_EVAL : ST_VERD;
      ST_VERD: if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Main register update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      test_lat_r <= '0; test_lon_r <= '0;
      cur_lat_r <= '0; cur_lon_r <= '0; start_lat_r <= '0; start_lon_r <= '0;
      prior_lat_r <= '0; prior_lon_r <= '0; prior_q_r <= '0; wind_r <= '0;
      have_start_r <= 1'b0; decided_r <= 1'b0; early_r <= '0;
      last_r <= 1'b0; closing_r <= 1'b0; out_valid_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ok) begin
        if (cfg_index == pipw_pkg::CFG_TEST_LAT) test_lat_r <= cfg_wdata[CB-1:0];
        else                                     test_lon_r <= cfg_wdata[CB-1:0];
      end
      // A verdict leaves the output register unless a new one replaces it.
      if (out_valid_r && out_ch.ready && (state_r != ST_VERD)) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            last_r    <= in_ch.data.last_vertex;
            closing_r <= 1'b0;
            if (!decided_r && nz) begin
              cur_lat_r <= cur_lat_r + dl;
              cur_lon_r <= cur_lon_r + dn;
              pt_lat_r  <= cur_lat_r + dl;
              pt_lon_r  <= cur_lon_r + dn;
            end
          end
        end
        ST_EVAL: begin
          q_r <= q_c;
          if (decided_r) begin
          end else if (hit) begin
            decided_r <= 1'b1; early_r <= pipw_pkg::VERDICT_BORDER;
          end else if (!have_start_r) begin
            start_lat_r <= pt_lat_r; start_lon_r <= pt_lon_r;
            have_start_r <= 1'b1;
            prior_lat_r <= pt_lat_r; prior_lon_r <= pt_lon_r; prior_q_r <= q_c;
          end else begin
            if (step_up) wind_r <= wind_r + 32'd1;
            else if (step_dn) wind_r <= wind_r - 32'd1;
            if (straight && (diag || between_ok)) begin
              decided_r <= 1'b1; early_r <= pipw_pkg::VERDICT_BORDER;
            end else if (!straight && diag) begin
              // Load |rise| * |dlon| multiplier and |dlat| divisor.
              mcand_r  <= PB'(magf(dlon));
              mplier_r <= magf(rise);
              div_r    <= magf(dlat);
              acc_r    <= '0;
              neg_r    <= (rise[CB] ^ dlon[CB]) ^ dlat[CB];
              cnt_r    <= '0;
            end else begin
              prior_lat_r <= pt_lat_r; prior_lon_r <= pt_lon_r; prior_q_r <= q_c;
            end
          end
        end
        ST_MUL: begin
          // One multiplier bit per cycle.
          if (mplier_r[0]) acc_r <= acc_r + mcand_r;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          cnt_r    <= (cnt_r == NB'(PB - 1)) ? '0 : cnt_r + NB'(1);
          if (cnt_r == NB'(PB - 1)) begin
            quo_r <= mplier_r[0] ? acc_r + mcand_r : acc_r;
            rem_r <= '0;
          end
        end
        ST_DIV: begin
          // One quotient bit per cycle.
          if (!rem_sub[PB]) begin
            rem_r <= rem_sub[PB-1:0];
            quo_r <= {quo_r[PB-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[PB-1:0];
            quo_r <= {quo_r[PB-2:0], 1'b0};
          end
          cnt_r <= cnt_r + NB'(1);
        end
        ST_FIN: begin
          if (border_x) begin
            decided_r <= 1'b1; early_r <= pipw_pkg::VERDICT_BORDER;
          end else begin
            if ((q_r >= 2'd2) == x_less) wind_r <= wind_r + 32'd2;
            else                         wind_r <= wind_r - 32'd2;
            prior_lat_r <= pt_lat_r; prior_lon_r <= pt_lon_r; prior_q_r <= q_r;
          end
        end
        ST_CLOSE: begin
          closing_r <= 1'b1;
          pt_lat_r  <= start_lat_r;
          pt_lon_r  <= start_lon_r;
        end
        ST_VERD: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            if (decided_r)                  out_verdict_r <= early_r;
            else if (wind_r == 32'hFFFF_FFFC) out_verdict_r <= pipw_pkg::VERDICT_IN;
            else if (wind_r == 32'd4)       out_verdict_r <= pipw_pkg::VERDICT_BORDER;
            else                            out_verdict_r <= pipw_pkg::VERDICT_OUT;
            cur_lat_r <= '0; cur_lon_r <= '0; start_lat_r <= '0; start_lon_r <= '0;
            prior_lat_r <= '0; prior_lon_r <= '0; prior_q_r <= '0; wind_r <= '0;
            have_start_r <= 1'b0; decided_r <= 1'b0; early_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Checks on sequencing and result consistency.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == ST_IDLE)) else $error("ready outside idle");
  a_verd_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_verdict_r != 2'd3)) else $error("bad verdict code");
  a_cnt_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (cnt_r < NB'(PB))) else $error("mul count overrun");
  a_div_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> ($past(state_r) == ST_MUL || $past(state_r) == ST_DIV))
    else $error("divide entered out of order");

endmodule

/* bench/point_in_polygon_winding_top_tb.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_winding_top_tb: self-checking bench for the polygon test
// Streams polygons of vertex deltas into the block under random flow control
// and compares every verdict with a predictor kept in the bench. Covers
// directed corner cases, several test-point settings and random polygons.
// ----------------------------------------------------------------------------
module point_in_polygon_winding_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  pipw_in_if  in_ch ();
  pipw_out_if out_ch ();

  point_in_polygon_winding_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state: test point and polygon in progress.
  int          pt_lat, pt_lon;
  int          cur_lat, cur_lon, first_lat, first_lon, prev_lat, prev_lon;
  logic [1:0]  prev_quad;
  logic [31:0] winding;
  bit          have_first, settled;
  logic [1:0]  settled_verdict;

  logic [1:0]  pending_verdicts[$];
  int          mismatches;
  int          verdicts_seen;
  int          vertices_sent;
  bit          hold_request;
  int          hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous fixed limit on the whole run.
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit lies_between(longint a, longint b, longint c);
    return (a <= b && b <= c) || (c <= b && b <= a);
  endfunction

  function automatic void clear_polygon();
    cur_lat = 0; cur_lon = 0; first_lat = 0; first_lon = 0;
    prev_lat = 0; prev_lon = 0; prev_quad = 2'd0; winding = '0;
    have_first = 1'b0; settled = 1'b0; settled_verdict = pipw_pkg::VERDICT_OUT;
  endfunction

  // Crossing longitude of the edge with lat = test lat, truncated to zero.
  function automatic longint crossing_lon(longint lat, longint lon,
                                          longint plat, longint plon);
    longint     dlat, dlon, rise, k;
    bit [127:0] num, den, quo, rem;
    bit         neg, frac;
    dlat = lat - plat;
    dlon = lon - plon;
    rise = longint'(pt_lat) - lat;
    num  = 128'(magnitude(rise)) * 128'(magnitude(dlon));
    den  = 128'(magnitude(dlat));
    quo  = num / den;
    rem  = num % den;
    neg  = ((rise < 0) != (dlon < 0)) != (dlat < 0);
    if (!neg) begin
      k = lon + longint'(quo[63:0]);
      frac = (rem != 0);
    end else if (rem != 0) begin
      k = lon - longint'(quo[63:0]) - 1;
      frac = 1'b1;
    end else begin
      k = lon - longint'(quo[63:0]);
      frac = 1'b0;
    end
    return (k < 0 && frac) ? k + 1 : k;
  endfunction

  // Fold one absolute point into the winding count.
  function automatic void visit_point(int lat_i, int lon_i);
    longint     lat, lon, x;
    logic [1:0] q;
    bit         straight, diag;
    logic [31:0] step;
    lat = lat_i;
    lon = lon_i;
    if (lat_i == pt_lat && lon_i == pt_lon) begin
      settled = 1'b1; settled_verdict = pipw_pkg::VERDICT_BORDER;
      return;
    end
    if (lat_i >= pt_lat) q = (lon_i >= pt_lon) ? 2'd0 : 2'd1;
    else                 q = (lon_i >= pt_lon) ? 2'd3 : 2'd2;
    if (have_first) begin
      straight = (lon_i == prev_lon) || (lat_i == prev_lat);
      diag = 1'b0;
      if (q == prev_quad) begin
      end else if (q == prev_quad + 2'd1) begin
        winding = winding + 32'd1;
      end else if (q + 2'd1 == prev_quad) begin
        winding = winding - 32'd1;
      end else begin
        diag = 1'b1;
      end
      if (straight) begin
        if (diag || (lies_between(lat, pt_lat, prev_lat) &&
                     lies_between(lon, pt_lon, prev_lon))) begin
          settled = 1'b1; settled_verdict = pipw_pkg::VERDICT_BORDER;
          return;
        end
      end else if (diag) begin
        x = crossing_lon(lat, lon, prev_lat, prev_lon);
        if (x >= longint'(pt_lon) - 1 && x <= longint'(pt_lon) + 1) begin
          settled = 1'b1; settled_verdict = pipw_pkg::VERDICT_BORDER;
          return;
        end
        step = (x < pt_lon) ? 32'd2 : 32'hFFFF_FFFE;
        if (q >= 2'd2) winding = winding + step;
        else           winding = winding - step;
      end
    end else begin
      first_lat = lat_i; first_lon = lon_i; have_first = 1'b1;
    end
    prev_lat = lat_i; prev_lon = lon_i; prev_quad = q;
  endfunction

  // Predict the effect of one accepted vertex request.
  function automatic void predict_vertex(pipw_pkg::in_req_t req);
    logic [1:0] v;
    if (!settled && (req.delta_lat != 0 || req.delta_lon != 0)) begin
      cur_lat = cur_lat + req.delta_lat;
      cur_lon = cur_lon + req.delta_lon;
      visit_point(cur_lat, cur_lon);
    end
    if (!req.last_vertex) return;
    if (!settled && have_first) visit_point(first_lat, first_lon);
    if (settled)                     v = settled_verdict;
    else if (winding == 32'hFFFF_FFFC) v = pipw_pkg::VERDICT_IN;
    else if (winding == 32'd4)       v = pipw_pkg::VERDICT_BORDER;
    else                             v = pipw_pkg::VERDICT_OUT;
    pending_verdicts.push_back(v);
    clear_polygon();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Send one vertex request; returns just after the accepting edge.
  task automatic send_vertex(int dlat, int dlon, bit last);
    int     gap;
    pipw_pkg::in_req_t req;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.delta_lat = dlat;
    req.delta_lon = dlon;
    req.last_vertex = last;
    in_ch.valid <= 1'b1;
    in_ch.data  <= req;
    do @(posedge clk); while (!in_ch.ready);
    predict_vertex(req);
    vertices_sent++;
  endtask

  // Send a polygon given by absolute points, closing it with the last one.
  task automatic send_polygon(int lats[$], int lons[$]);
    int plat, plon;
    plat = 0;
    plon = 0;
    foreach (lats[i]) begin
      send_vertex(lats[i] - plat, lons[i] - plon, i == lats.size() - 1);
      plat = lats[i];
      plon = lons[i];
    end
  endtask

  // Wait for all verdicts, then let any trailing work finish.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pipw_pkg::CFG_TEST_LAT) pt_lat = value;
    else                               pt_lon = value;
  endtask

  task automatic set_test_point(int lat, int lon);
    drain();
    write_reg(pipw_pkg::CFG_TEST_LAT, lat);
    write_reg(pipw_pkg::CFG_TEST_LON, lon);
  endtask

  // Directed corner cases around the current test point.
  task automatic test_directed();
    int a, b;
    a = pt_lat;
    b = pt_lon;
    // Empty polygon.
    send_vertex(0, 0, 1'b1);
    // Clockwise square around the point: inside.
    send_polygon('{a + 5, a - 5, a - 5, a + 5}, '{b + 5, b + 5, b - 5, b - 5});
    // Counterclockwise square: reported as border.
    send_polygon('{a + 5, a + 5, a - 5, a - 5}, '{b + 5, b - 5, b - 5, b + 5});
    // Vertex hit, followed by ignored vertices after the decision.
    send_vertex(a, b, 1'b0);
    send_vertex(7, -3, 1'b0);
    send_vertex(0, 9, 1'b1);
    // Test point on an axis-aligned edge.
    send_polygon('{a - 4, a + 4, a + 4}, '{b, b, b + 6});
    // Diagonal crossings, one passing near the point, one far from it.
    send_polygon('{a + 10, a - 10, a + 10}, '{b + 9, b - 11, b - 30});
    send_polygon('{a + 10, a - 10, a - 10}, '{b + 40, b - 20, b + 60});
    // Single point, then zero delta on the last item.
    send_vertex(a + 3, b - 2, 1'b1);
    send_vertex(a + 3, b + 3, 1'b0);
    send_vertex(-6, 0, 1'b0);
    send_vertex(0, 0, 1'b1);
    // Extreme deltas.
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
  endtask

  // Random polygons near the test point, with some noise.
  task automatic test_random(int count);
    int lats[$], lons[$];
    int n, spread, sel;
    while (count > 0) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        send_vertex($urandom, $urandom, $urandom_range(1));
        count--;
      end else begin
        lats.delete();
        lons.delete();
        n = (sel < 12) ? 1 : $urandom_range(8, 3);
        case ($urandom_range(3))
          0:       spread = 4;
          1:       spread = 100;
          2:       spread = 1 << 20;
          default: spread = 32'h3FFF_FFFF;
        endcase
        for (int i = 0; i < n; i++) begin
          lats.push_back(pt_lat + $urandom_range(2 * spread) - spread);
          lons.push_back(pt_lon + $urandom_range(2 * spread) - spread);
        end
        send_polygon(lats, lons);
        count -= n;
      end
    end
  endtask

  // Stall the verdict side for a long stretch while vertices keep coming.
  task automatic test_back_pressure();
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    test_random(60);
  endtask

  // Verdict side: random ready, long holds on request, and checking.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        verdicts_seen++;
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected verdict %0d", out_ch.data.verdict);
        end else begin
          if (out_ch.data.verdict !== pending_verdicts[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("verdict mismatch: expected %0d actual %0d",
                       pending_verdicts[0], out_ch.data.verdict);
          end
          void'(pending_verdicts.pop_front());
        end
      end
      if (hold_request) begin
        hold_left    <= 600;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(99) < 3) begin
        hold_left    <= $urandom_range(40, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) < 75);
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = pipw_pkg::CFG_TEST_LAT;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    hold_request = 1'b0;
    mismatches   = 0;
    verdicts_seen = 0;
    vertices_sent = 0;
    pt_lat = 0;
    pt_lon = 0;
    clear_polygon();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    set_test_point(32'h7FFF_FFF0, 32'h8000_0010);
    test_directed();
    test_random(250);
    set_test_point(32'h8000_0000, 32'h7FFF_FFFF);
    test_random(200);
    set_test_point(12345, -6789);
    test_back_pressure();
    test_random(250);
    set_test_point($urandom, $urandom);
    test_random(300);

    drain();
    $display("sent %0d vertices, checked %0d verdicts over five test points",
             vertices_sent, verdicts_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
